[hw/rtl/si_pkg.sv]
package si_pkg;

  localparam int COORD_WIDTH = 24;
  localparam int S_FRAC_BITS = 16;

  // widths of differences, products and cross products
  localparam int DW = COORD_WIDTH + 1;
  localparam int PW = 2 * DW;
  localparam int NW = PW + 1;

  // width of a direction scaled by s
  localparam int MW = DW + S_FRAC_BITS + 1;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] seg_a_start_x;
    logic signed [COORD_WIDTH-1:0] seg_a_start_y;
    logic signed [COORD_WIDTH-1:0] seg_a_end_x;
    logic signed [COORD_WIDTH-1:0] seg_a_end_y;
    logic signed [COORD_WIDTH-1:0] seg_b_start_x;
    logic signed [COORD_WIDTH-1:0] seg_b_start_y;
    logic signed [COORD_WIDTH-1:0] seg_b_end_x;
    logic signed [COORD_WIDTH-1:0] seg_b_end_y;
  } in_t;

  typedef struct packed {
    logic                          hit;
    logic [S_FRAC_BITS-1:0]        frac_along_a;
    logic signed [COORD_WIDTH-1:0] cross_x;
    logic signed [COORD_WIDTH-1:0] cross_y;
  } out_t;

  // fields carried alongside the divider
  typedef struct packed {
    logic                          hit;
    logic signed [DW-1:0]          ax;
    logic signed [DW-1:0]          ay;
    logic signed [COORD_WIDTH-1:0] a0x;
    logic signed [COORD_WIDTH-1:0] a0y;
  } pass_t;

  typedef struct packed {
    logic                   valid;
    logic [NW-1:0]          rem;
    logic [NW-1:0]          d;
    logic [S_FRAC_BITS-1:0] q;
    pass_t                  pass;
  } div_t;

  function automatic logic signed [DW-1:0] sx(logic signed [COORD_WIDTH-1:0] v);
    return {v[COORD_WIDTH-1], v};
  endfunction

endpackage

[hw/rtl/si_cross.sv]
module si_cross (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  logic         valid_in,
  input  si_pkg::in_t  data_in,
  output si_pkg::div_t st
);
  import si_pkg::*;

  // stage 1: direction vectors and offset
  logic                          v1;
  logic signed [DW-1:0]          ax1, ay1, bx1, by1, wx1, wy1;
  logic signed [COORD_WIDTH-1:0] a0x1, a0y1;
  // stage 2: products
  logic                          v2;
  logic signed [PW-1:0]          p_ab, p_ba, p_wb, p_vb, p_wa, p_va;
  logic signed [DW-1:0]          ax2, ay2;
  logic signed [COORD_WIDTH-1:0] a0x2, a0y2;
  // stage 3: cross products
  logic                          v3;
  logic signed [NW-1:0]          d3, sn3, tn3;
  logic signed [DW-1:0]          ax3, ay3;
  logic signed [COORD_WIDTH-1:0] a0x3, a0y3;
  // stage 4: sign normalized
  logic                          v4, dz4;
  logic signed [NW-1:0]          d4, sn4, tn4;
  logic signed [DW-1:0]          ax4, ay4;
  logic signed [COORD_WIDTH-1:0] a0x4, a0y4;

  always_ff @(posedge clk) begin
    // stage valid bits
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      st.valid <= 1'b0;
    end else if (en) begin
      v1 <= valid_in;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      st.valid <= v4;
    end
    if (en) begin
      // differences
      ax1  <= sx(data_in.seg_a_end_x) - sx(data_in.seg_a_start_x);
      ay1  <= sx(data_in.seg_a_end_y) - sx(data_in.seg_a_start_y);
      bx1  <= sx(data_in.seg_b_end_x) - sx(data_in.seg_b_start_x);
      by1  <= sx(data_in.seg_b_end_y) - sx(data_in.seg_b_start_y);
      wx1  <= sx(data_in.seg_b_start_x) - sx(data_in.seg_a_start_x);
      wy1  <= sx(data_in.seg_b_start_y) - sx(data_in.seg_a_start_y);
      a0x1 <= data_in.seg_a_start_x;
      a0y1 <= data_in.seg_a_start_y;
      // products
      p_ab <= ax1 * by1;
      p_ba <= ay1 * bx1;
      p_wb <= wx1 * by1;
      p_vb <= wy1 * bx1;
      p_wa <= wx1 * ay1;
      p_va <= wy1 * ax1;
      ax2  <= ax1;
      ay2  <= ay1;
      a0x2 <= a0x1;
      a0y2 <= a0y1;
      // cross products
      d3   <= NW'(p_ab) - NW'(p_ba);
      sn3  <= NW'(p_wb) - NW'(p_vb);
      tn3  <= NW'(p_wa) - NW'(p_va);
      ax3  <= ax2;
      ay3  <= ay2;
      a0x3 <= a0x2;
      a0y3 <= a0y2;
      // make the denominator positive
      dz4  <= (d3 == '0);
      d4   <= d3[NW-1] ? -d3 : d3;
      sn4  <= d3[NW-1] ? -sn3 : sn3;
      tn4  <= d3[NW-1] ? -tn3 : tn3;
      ax4  <= ax3;
      ay4  <= ay3;
      a0x4 <= a0x3;
      a0y4 <= a0y3;
      // strict interior test, divider seed
      st.pass.hit <= !dz4 && (sn4 > 0) && (sn4 < d4) && (tn4 > 0) && (tn4 < d4);
      st.rem      <= sn4;
      st.d        <= d4;
      st.q        <= '0;
      st.pass.ax  <= ax4;
      st.pass.ay  <= ay4;
      st.pass.a0x <= a0x4;
      st.pass.a0y <= a0y4;
    end
  end

endmodule

[hw/rtl/si_div_stage.sv]
module si_div_stage (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  si_pkg::div_t st_in,
  output si_pkg::div_t st_out
);
  import si_pkg::*;

  logic [NW-1:0] r2;
  logic          ge;

  // one restoring quotient bit
  assign r2 = {st_in.rem[NW-2:0], 1'b0};
  assign ge = (r2 >= st_in.d);

  always_ff @(posedge clk) begin
    if (rst) begin
      st_out.valid <= 1'b0;
    end else if (en) begin
      st_out.valid <= st_in.valid;
      st_out.rem   <= ge ? r2 - st_in.d : r2;
      st_out.d     <= st_in.d;
      st_out.q     <= {st_in.q[S_FRAC_BITS-2:0], ge};
      st_out.pass  <= st_in.pass;
    end
  end

endmodule

[hw/rtl/si_point.sv]
module si_point (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  si_pkg::div_t st_in,
  output logic         valid_out,
  output si_pkg::out_t data_out
);
  import si_pkg::*;

  logic                          v1, hit1;
  logic signed [MW-1:0]          mx, my;
  logic [S_FRAC_BITS-1:0]        q1;
  logic signed [COORD_WIDTH-1:0] a0x1, a0y1;
  logic signed [MW-1:0]          sx_sh, sy_sh;
  logic signed [MW-1:0]          px, py;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      valid_out <= 1'b0;
    end else if (en) begin
      v1 <= st_in.valid;
      valid_out <= v1;
    end
  end

  // floor shift is an arithmetic shift
  assign sx_sh = mx >>> S_FRAC_BITS;
  assign sy_sh = my >>> S_FRAC_BITS;
  assign px    = MW'(a0x1) + sx_sh;
  assign py    = MW'(a0y1) + sy_sh;

  always_ff @(posedge clk) begin
    if (en) begin
      // scale direction by s
      mx   <= st_in.pass.ax * $signed({1'b0, st_in.q});
      my   <= st_in.pass.ay * $signed({1'b0, st_in.q});
      q1   <= st_in.q;
      hit1 <= st_in.pass.hit;
      a0x1 <= st_in.pass.a0x;
      a0y1 <= st_in.pass.a0y;
      // result word, zero on miss
      data_out.hit          <= hit1;
      data_out.frac_along_a <= hit1 ? q1 : '0;
      data_out.cross_x      <= hit1 ? px[COORD_WIDTH-1:0] : '0;
      data_out.cross_y      <= hit1 ? py[COORD_WIDTH-1:0] : '0;
    end
  end

endmodule

[hw/rtl/segment_intersection.sv]
// an accepted word passes the cross-product, divider and point stages
// throughput: one word per cycle unless stalled, set by a fully pipelined
//   datapath, one quotient bit per divider stage, every multiplier registered
// reset: synchronous active-high rst clears all stage valid bits
module segment_intersection (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  input  si_pkg::in_t  in_data,
  output logic         out_valid,
  input  logic         out_stall,
  output si_pkg::out_t out_data
);
  import si_pkg::*;

  logic en;
  div_t chain [S_FRAC_BITS+1];

  // whole pipeline holds while the result word waits
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  si_cross u_cross (
    .clk(clk), .rst(rst), .en(en),
    .valid_in(in_valid), .data_in(in_data), .st(chain[0])
  );

  // quotient bits, most significant first
  for (genvar i = 0; i < S_FRAC_BITS; i++) begin : g_div
    si_div_stage u_stage (
      .clk(clk), .rst(rst), .en(en),
      .st_in(chain[i]), .st_out(chain[i+1])
    );
  end

  si_point u_point (
    .clk(clk), .rst(rst), .en(en),
    .st_in(chain[S_FRAC_BITS]), .valid_out(out_valid), .data_out(out_data)
  );

endmodule

[hw/rtl/si_checker.sv]
module si_checker (
  input logic         clk,
  input logic         rst,
  input logic         in_stall,
  input logic         out_valid,
  input logic         out_stall,
  input si_pkg::out_t out_data
);
  import si_pkg::*;

  // stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result word changed under stall");

  // a miss carries zero fields
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.hit |->
      out_data.frac_along_a == '0 && out_data.cross_x == '0 && out_data.cross_y == '0)
    else $error("miss with nonzero fields");

  // input stalls only behind a stalled result
  a_in_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("input stall without output stall");

  // reset empties the pipeline
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result after reset");

endmodule

bind segment_intersection si_checker u_si_checker (
  .clk(clk), .rst(rst), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);

[tb/sv/segment_intersection_tb.sv]
`timescale 1ns / 100ps

module segment_intersection_tb;
  import si_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LATENCY = 23;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int fail_count = 0;
  int quiet_cycles = 0;
  out_t crossing_queue[$];

  segment_intersection dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #5 clk = ~clk;

  // floor of p / 2^16 for a signed product
  function automatic longint floor_s(longint p);
    return p >>> S_FRAC_BITS;
  endfunction

  // exact crossing test of the two segments
  function automatic out_t predict_crossing(in_t w);
    longint a0x, a0y, ax, ay, bx, by, wx, wy, d, sn, tn, rem, s;
    out_t r;
    a0x = longint'(w.seg_a_start_x);
    a0y = longint'(w.seg_a_start_y);
    ax = longint'(w.seg_a_end_x) - a0x;
    ay = longint'(w.seg_a_end_y) - a0y;
    bx = longint'(w.seg_b_end_x) - longint'(w.seg_b_start_x);
    by = longint'(w.seg_b_end_y) - longint'(w.seg_b_start_y);
    wx = longint'(w.seg_b_start_x) - a0x;
    wy = longint'(w.seg_b_start_y) - a0y;
    d = ax * by - ay * bx;
    sn = wx * by - wy * bx;
    tn = wx * ay - wy * ax;
    r = '0;
    if (d == 0) return r;
    if (d < 0) begin
      d = -d; sn = -sn; tn = -tn;
    end
    if (!(sn > 0 && sn < d && tn > 0 && tn < d)) return r;
    rem = sn;
    s = 0;
    for (int i = 0; i < S_FRAC_BITS; i++) begin
      rem = rem << 1;
      s = s << 1;
      if (rem >= d) begin
        rem = rem - d;
        s = s | 1;
      end
    end
    r.hit = 1'b1;
    r.frac_along_a = s[S_FRAC_BITS-1:0];
    r.cross_x = COORD_WIDTH'(a0x + floor_s(ax * s));
    r.cross_y = COORD_WIDTH'(a0y + floor_s(ay * s));
    return r;
  endfunction

  function automatic logic [COORD_WIDTH-1:0] rand_coord();
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) return {1'b0, {(COORD_WIDTH-1){1'b1}}};
    if (k == 1) return {1'b1, {(COORD_WIDTH-1){1'b0}}};
    if (k < 5) return COORD_WIDTH'($urandom);
    return COORD_WIDTH'(int'($urandom_range(0, 4000)) - 2000);
  endfunction

  // send one word, holding it while stalled
  task automatic send_word(in_t w);
    while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    crossing_queue.push_back(predict_crossing(w));
  endtask

  task automatic send_pts(longint ax0, longint ay0, longint ax1, longint ay1,
                          longint bx0, longint by0, longint bx1, longint by1);
    in_t w;
    w.seg_a_start_x = COORD_WIDTH'(ax0); w.seg_a_start_y = COORD_WIDTH'(ay0);
    w.seg_a_end_x = COORD_WIDTH'(ax1);   w.seg_a_end_y = COORD_WIDTH'(ay1);
    w.seg_b_start_x = COORD_WIDTH'(bx0); w.seg_b_start_y = COORD_WIDTH'(by0);
    w.seg_b_end_x = COORD_WIDTH'(bx1);   w.seg_b_end_y = COORD_WIDTH'(by1);
    send_word(w);
  endtask

  // receiver stall and result check
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (crossing_queue.size() == 0) begin
          $error("unexpected result word");
          fail_count++;
        end else begin
          out_t e;
          e = crossing_queue.pop_front();
          if (out_data.hit !== e.hit) begin
            $error("hit expected %0d actual %0d", e.hit, out_data.hit);
            fail_count++;
          end
          if (out_data.frac_along_a !== e.frac_along_a) begin
            $error("frac_along_a expected %0h actual %0h", e.frac_along_a,
                   out_data.frac_along_a);
            fail_count++;
          end
          if (out_data.cross_x !== e.cross_x) begin
            $error("cross_x expected %0h actual %0h", e.cross_x, out_data.cross_x);
            fail_count++;
          end
          if (out_data.cross_y !== e.cross_y) begin
            $error("cross_y expected %0h actual %0h", e.cross_y, out_data.cross_y);
            fail_count++;
          end
        end
      end
      out_stall <= (recv_idle_pct > 0) && ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // extremes, parallel, collinear and endpoint cases
  task automatic test_directed();
    longint mx, mn;
    mx = (1 << (COORD_WIDTH-1)) - 1;
    mn = -(1 << (COORD_WIDTH-1));
    send_pts(0, 0, 256, 256, 0, 256, 256, 0);
    send_pts(mn, mn, mx, mx, mn, mx, mx, mn);
    send_pts(mx, mx, mn, mn, mx, mn, mn, mx);
    send_pts(mn, 0, mx, 0, 0, mn, 0, mx);
    send_pts(0, 0, 100, 0, 0, 10, 100, 10);
    send_pts(0, 0, 100, 0, 10, 0, 50, 0);
    send_pts(0, 0, 100, 100, 50, 50, 50, 50);
    send_pts(0, 0, 0, 0, 0, 0, 0, 0);
    send_pts(0, 0, 100, 0, 0, -50, 0, 50);
    send_pts(0, 0, 100, 0, 100, -50, 100, 50);
    send_pts(0, 0, 100, 0, 50, 0, 50, 50);
    send_pts(0, 0, 100, 0, 50, 50, 50, 0);
    send_pts(0, 0, 100, 0, 50, 1, 50, 50);
    send_pts(-300, 7, 900, -5, 1, -1000, 3, 1000);
    send_pts(mx, mn, mn, mx, mn, mn, mx, mx);
    send_pts(0, 0, 1, 1, 0, 1, 1, 0);
    send_pts(5, 5, -7, -3, -6, 4, 2, -9);
    send_pts(-1, -1, -1, -1, -1, -1, -1, -1);
  endtask

  // random pairs, mostly built to cross
  task automatic test_random(int n);
    in_t w;
    longint cx, cy, r;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 2) == 0) begin
        w = {rand_coord(), rand_coord(), rand_coord(), rand_coord(),
             rand_coord(), rand_coord(), rand_coord(), rand_coord()};
        send_word(w);
      end else begin
        r = (longint'(1) << $urandom_range(2, 22));
        cx = longint'(int'($urandom_range(0, 4000000))) - 2000000;
        cy = longint'(int'($urandom_range(0, 4000000))) - 2000000;
        send_pts(cx - longint'($urandom_range(1, r)), cy - longint'($urandom_range(0, r)),
                 cx + longint'($urandom_range(1, r)), cy + longint'($urandom_range(0, r)),
                 cx - longint'($urandom_range(0, r)), cy + longint'($urandom_range(1, r)),
                 cx + longint'($urandom_range(0, r)), cy - longint'($urandom_range(1, r)));
      end
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (crossing_queue.size() != 0) @(posedge clk);
    repeat (2 * LATENCY) @(posedge clk);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle_pct = 25; recv_idle_pct = 45;
    test_directed();
    test_random(650);
    send_idle_pct = 45; recv_idle_pct = 25;
    test_random(650);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(700);
    drain();
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

[sim.f]
hw/rtl/si_pkg.sv
hw/rtl/si_cross.sv
hw/rtl/si_div_stage.sv
hw/rtl/si_point.sv
hw/rtl/segment_intersection.sv
hw/rtl/si_checker.sv
tb/sv/segment_intersection_tb.sv
